>>> hw/rtl/iibs_pkg.sv
// Shared constants and helpers for the summed-area table box-sum block.
package iibs_pkg;

   // Transaction kinds carried by the command field.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Configuration register indexes.
   localparam int   CSR_INDEX_W      = 1;
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // Field widths.
   localparam int SIZE_REG_W = 10;
   localparam int PIXEL_W    = 8;
   localparam int COORD_W    = 11;
   localparam int ENTRY_W    = 27;
   localparam int SUM_W      = 26;

   // A row holds at most 1023 pixels of up to 255 each.
   localparam int ROW_SUM_W = 18;

   // Effective image sizes never exceed the 10-bit size register; size compares use 13 bits.
   localparam int SIZE_W = 13;

   // Signed width for corner arithmetic: coordinate plus extent plus sign.
   localparam int CALC_W = 14;

   // Accumulator for A - B + C - D over 27-bit entries, with sign.
   localparam int ACC_W = 30;

   localparam int CORNERS = 4;

   localparam int QUEUE_DEPTH = 2;

   localparam int DEFAULT_MAX_WIDTH  = 512;
   localparam int DEFAULT_MAX_HEIGHT = 512;

   localparam logic [SIZE_REG_W-1:0] SIZE_RESET = SIZE_REG_W'(512);
   localparam logic [SUM_W-1:0]      SUM_MAX    = '1;

   // Width of one classified transaction as it travels through the queue.
   function automatic int item_width(input int addr_w);
      return 1 + ROW_SUM_W + CORNERS * addr_w + CORNERS;
   endfunction

endpackage

>>> hw/rtl/integral_image_box_sum.sv
// Summed-area table with box-sum queries. Load transactions (command 0) take one
// red pixel each in raster order; first_pixel restarts the raster at the top-left
// corner. Query transactions (command 1) return the sum of the red values inside
// a box clamped to the image, saturated to 26 bits; loads return nothing. The
// table has 2**(clog2(MAX_HEIGHT)+clog2(MAX_WIDTH)) entries of 27 bits with a
// single read port and needs no clearing after reset; a query must only cover
// pixels already loaded. A load occupies the back end for a single step and a
// query for one step per corner read on the table's read port; loads go in at
// one per cycle unless a query is walking its corners or held at the output.
// A query's sum is formed in the read stage and held in the output register.
// The user must write the size registers through the csr_ port only while the
// block is idle; the block itself does not enforce this.
module integral_image_box_sum #(
   parameter int MAX_WIDTH  = iibs_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = iibs_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [iibs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [iibs_pkg::SIZE_REG_W-1:0]      csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [iibs_pkg::PIXEL_W-1:0]         req_pixel_red,
   input  logic                                 req_first_pixel,
   input  logic signed [iibs_pkg::COORD_W-1:0]  req_top_row,
   input  logic signed [iibs_pkg::COORD_W-1:0]  req_left_col,
   input  logic [iibs_pkg::COORD_W-1:0]         req_row_count,
   input  logic [iibs_pkg::COORD_W-1:0]         req_col_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [iibs_pkg::SUM_W-1:0]           rsp_box_sum
);

   localparam int AW     = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
   localparam int ITEM_W = iibs_pkg::item_width(AW);

   logic              push_valid, push_ready;
   logic [ITEM_W-1:0] push_data;
   logic              pop_valid, pop_ready;
   logic [ITEM_W-1:0] pop_data;

   // Front end: size registers, raster position and address generation.
   iibs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_pixel_red   (req_pixel_red),
      .req_first_pixel (req_first_pixel),
      .req_top_row     (req_top_row),
      .req_left_col    (req_left_col),
      .req_row_count   (req_row_count),
      .req_col_count   (req_col_count),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   // Decoupling queue.
   iibs_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (iibs_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back end: table memory, corner reads and result register.
   iibs_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_box_sum (rsp_box_sum)
   );

endmodule

>>> hw/rtl/iibs_front.sv
// Front end: holds the size registers and the raster position, and turns each
// accepted transaction into a classified item with its table addresses.
module iibs_front #(
   parameter int  MAX_WIDTH  = iibs_pkg::DEFAULT_MAX_WIDTH,
   parameter int  MAX_HEIGHT = iibs_pkg::DEFAULT_MAX_HEIGHT,
   localparam int CB         = $clog2(MAX_WIDTH),
   localparam int RB         = $clog2(MAX_HEIGHT),
   localparam int AW         = RB + CB,
   localparam int ITEM_W     = iibs_pkg::item_width(AW)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [iibs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [iibs_pkg::SIZE_REG_W-1:0]      csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [iibs_pkg::PIXEL_W-1:0]         req_pixel_red,
   input  logic                                 req_first_pixel,
   input  logic signed [iibs_pkg::COORD_W-1:0]  req_top_row,
   input  logic signed [iibs_pkg::COORD_W-1:0]  req_left_col,
   input  logic [iibs_pkg::COORD_W-1:0]         req_row_count,
   input  logic [iibs_pkg::COORD_W-1:0]         req_col_count,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output logic [ITEM_W-1:0]                    push_data
);

   typedef struct packed {
      logic                                         is_query;
      logic [iibs_pkg::ROW_SUM_W-1:0]               row_sum;
      logic [iibs_pkg::CORNERS-1:0][AW-1:0]         addr;
      logic [iibs_pkg::CORNERS-1:0]                 corner_en;
   } item_type;

   localparam int SW = iibs_pkg::SIZE_W;
   localparam int KW = iibs_pkg::CALC_W;

   logic [iibs_pkg::SIZE_REG_W-1:0] width_ff, width_in;
   logic [iibs_pkg::SIZE_REG_W-1:0] height_ff, height_in;
   logic [RB-1:0]                   load_row_ff, load_row_in;
   logic [CB-1:0]                   load_col_ff, load_col_in;
   logic [iibs_pkg::ROW_SUM_W-1:0]  row_sum_ff, row_sum_in;

   logic                            accept;
   logic [SW-1:0]                   width_eff, height_eff;
   logic [RB-1:0]                   start_row;
   logic [CB-1:0]                   start_col;
   logic [iibs_pkg::ROW_SUM_W-1:0]  start_sum, sum_now;
   logic [SW-1:0]                   col_inc, row_inc;

   logic signed [KW-1:0] row_s, col_s, rows_s, cols_s, h_s, w_s;
   logic signed [KW-1:0] row_end, col_end, r1, c1, r2, c2;
   logic                 r1_ok, c1_ok, r2_ok, c2_ok;

   item_type item;

   // The queue applies back pressure directly to the request channel.
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign push_data  = item;
   assign accept     = req_valid & req_ready;
   assign csr_ready  = 1'b1;

   // Effective sizes: zero counts as one, and sizes beyond the table clamp.
   always_comb begin
      if (width_ff == '0) begin
         width_eff = SW'(1);
      end else if (SW'(width_ff) > SW'(MAX_WIDTH)) begin
         width_eff = SW'(MAX_WIDTH);
      end else begin
         width_eff = SW'(width_ff);
      end
      if (height_ff == '0) begin
         height_eff = SW'(1);
      end else if (SW'(height_ff) > SW'(MAX_HEIGHT)) begin
         height_eff = SW'(MAX_HEIGHT);
      end else begin
         height_eff = SW'(height_ff);
      end
   end

   // Raster position for a load; a first pixel restarts at the top-left corner.
   always_comb begin
      start_row = req_first_pixel ? '0 : load_row_ff;
      start_col = req_first_pixel ? '0 : load_col_ff;
      start_sum = req_first_pixel ? '0 : row_sum_ff;
      sum_now   = start_sum + iibs_pkg::ROW_SUM_W'(req_pixel_red);
      col_inc   = SW'(start_col) + SW'(1);
      row_inc   = SW'(start_row) + SW'(1);
   end

   // Box corners, clamped to the image; a negative corner contributes zero.
   always_comb begin
      row_s   = KW'(req_top_row);
      col_s   = KW'(req_left_col);
      rows_s  = KW'(req_row_count);
      cols_s  = KW'(req_col_count);
      h_s     = KW'(height_eff);
      w_s     = KW'(width_eff);
      row_end = row_s + rows_s;
      col_end = col_s + cols_s;
      r1      = ((row_s < h_s) ? row_s : h_s) - KW'(1);
      c1      = ((col_s < w_s) ? col_s : w_s) - KW'(1);
      r2      = ((row_end < h_s) ? row_end : h_s) - KW'(1);
      c2      = ((col_end < w_s) ? col_end : w_s) - KW'(1);
      r1_ok   = ~r1[KW-1];
      c1_ok   = ~c1[KW-1];
      r2_ok   = ~r2[KW-1];
      c2_ok   = ~c2[KW-1];
   end

   // Classified item: a load carries the entry above in slot 0 and the write
   // address in slot 1; a query carries its four corners in A, B, C, D order.
   always_comb begin
      item = '0;
      if (req_command == iibs_pkg::CMD_QUERY) begin
         item.is_query     = 1'b1;
         item.addr[0]      = {r1[RB-1:0], c1[CB-1:0]};
         item.addr[1]      = {r1[RB-1:0], c2[CB-1:0]};
         item.addr[2]      = {r2[RB-1:0], c2[CB-1:0]};
         item.addr[3]      = {r2[RB-1:0], c1[CB-1:0]};
         item.corner_en[0] = r1_ok & c1_ok;
         item.corner_en[1] = r1_ok & c2_ok;
         item.corner_en[2] = r2_ok & c2_ok;
         item.corner_en[3] = r2_ok & c1_ok;
      end else begin
         item.is_query     = 1'b0;
         item.row_sum      = sum_now;
         item.addr[0]      = {start_row - RB'(1), start_col};
         item.addr[1]      = {start_row, start_col};
         item.corner_en[0] = (start_row != '0);
      end
   end

   // Size register writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            iibs_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata;
            end
            iibs_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
            end
         endcase
      end
   end

   // Raster advance after each stored pixel.
   always_comb begin
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      row_sum_in  = row_sum_ff;
      if (accept && (req_command == iibs_pkg::CMD_LOAD)) begin
         if (col_inc >= width_eff) begin
            load_col_in = '0;
            row_sum_in  = '0;
            load_row_in = (row_inc >= height_eff) ? '0 : row_inc[RB-1:0];
         end else begin
            load_col_in = col_inc[CB-1:0];
            row_sum_in  = sum_now;
            load_row_in = start_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= iibs_pkg::SIZE_RESET;
         height_ff   <= iibs_pkg::SIZE_RESET;
         load_row_ff <= '0;
         load_col_ff <= '0;
         row_sum_ff  <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         load_row_ff <= load_row_in;
         load_col_ff <= load_col_in;
         row_sum_ff  <= row_sum_in;
      end
   end

endmodule

>>> hw/rtl/iibs_queue.sv
// Small FIFO of classified items between the front end and the back end.
module iibs_queue #(
   parameter int  WIDTH = iibs_pkg::item_width(1),
   parameter int  DEPTH = iibs_pkg::QUEUE_DEPTH,
   localparam int PW    = $clog2(DEPTH),
   localparam int NW    = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/iibs_back.sv
// Back end: owns the table memory, performs the read-add-write of a load and
// the four corner reads of a query, and holds the result register.
module iibs_back #(
   parameter int  MAX_WIDTH  = iibs_pkg::DEFAULT_MAX_WIDTH,
   parameter int  MAX_HEIGHT = iibs_pkg::DEFAULT_MAX_HEIGHT,
   localparam int CB         = $clog2(MAX_WIDTH),
   localparam int RB         = $clog2(MAX_HEIGHT),
   localparam int AW         = RB + CB,
   localparam int ITEM_W     = iibs_pkg::item_width(AW)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  logic [ITEM_W-1:0]            pop_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [iibs_pkg::SUM_W-1:0]   rsp_box_sum
);

   typedef struct packed {
      logic                                         is_query;
      logic [iibs_pkg::ROW_SUM_W-1:0]               row_sum;
      logic [iibs_pkg::CORNERS-1:0][AW-1:0]         addr;
      logic [iibs_pkg::CORNERS-1:0]                 corner_en;
   } item_type;

   localparam int EW = iibs_pkg::ENTRY_W;
   localparam int XW = iibs_pkg::ACC_W;
   localparam int SW = $clog2(iibs_pkg::CORNERS);
   localparam logic [SW-1:0] STEP_LAST = SW'(iibs_pkg::CORNERS - 1);

   logic [EW-1:0] table_ff [2**AW];
   logic [EW-1:0] mem_q_ff;

   logic [SW-1:0]                  step_ff, step_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic                           rd_load_ff, rd_load_in;
   logic                           rd_last_ff, rd_last_in;
   logic                           rd_en_ff, rd_en_in;
   logic                           rd_neg_ff, rd_neg_in;
   logic [AW-1:0]                  rd_wr_addr_ff, rd_wr_addr_in;
   logic [iibs_pkg::ROW_SUM_W-1:0] rd_sum_ff, rd_sum_in;
   logic                           hit_ff, hit_in;
   logic [EW-1:0]                  fwd_ff, fwd_in;
   logic [XW-1:0]                  acc_ff, acc_in;
   logic                           out_valid_ff, out_valid_in;
   logic [iibs_pkg::SUM_W-1:0]     out_sum_ff, out_sum_in;

   item_type                   head;
   logic                       stall, issue, issue_last, wr_en, result_en;
   logic [AW-1:0]              rd_addr;
   logic [EW-1:0]              rd_data, term, wr_data;
   logic [XW-1:0]              acc_step;
   logic [iibs_pkg::SUM_W-1:0] clamped;

   assign head = item_type'(pop_data);

   // Issue control: a query result waits while the output register is full.
   assign stall      = rd_valid_ff & rd_last_ff & ~rd_load_ff & out_valid_ff & ~rsp_ready;
   assign issue      = pop_valid & ~stall;
   assign issue_last = ~head.is_query | (step_ff == STEP_LAST);
   assign pop_ready  = issue & issue_last;
   assign rd_addr    = head.addr[step_ff];

   // Read data, with a bypass for a write to the same entry in the issue cycle.
   assign rd_data = hit_ff ? fwd_ff : mem_q_ff;
   assign term    = rd_en_ff ? rd_data : '0;
   assign wr_en   = rd_valid_ff & rd_load_ff;
   assign wr_data = EW'(EW'(rd_sum_ff) + term);

   // Signed accumulation of the corners, then clamping into the result range.
   always_comb begin
      acc_step = rd_neg_ff ? (acc_ff - XW'(term)) : (acc_ff + XW'(term));
      if (acc_step[XW-1]) begin
         clamped = '0;
      end else if (acc_step > XW'(iibs_pkg::SUM_MAX)) begin
         clamped = iibs_pkg::SUM_MAX;
      end else begin
         clamped = acc_step[iibs_pkg::SUM_W-1:0];
      end
   end

   assign result_en = rd_valid_ff & ~rd_load_ff & rd_last_ff & ~stall;

   // Step counter walks the corners of a query; a load uses one step.
   always_comb begin
      step_in = step_ff;
      if (issue) begin
         step_in = issue_last ? '0 : step_ff + SW'(1);
      end
   end

   // Read stage holds while a finished query waits for the output register.
   always_comb begin
      rd_valid_in   = rd_valid_ff;
      rd_load_in    = rd_load_ff;
      rd_last_in    = rd_last_ff;
      rd_en_in      = rd_en_ff;
      rd_neg_in     = rd_neg_ff;
      rd_wr_addr_in = rd_wr_addr_ff;
      rd_sum_in     = rd_sum_ff;
      hit_in        = hit_ff;
      fwd_in        = fwd_ff;
      if (!stall) begin
         rd_valid_in   = issue;
         rd_load_in    = ~head.is_query;
         rd_last_in    = issue_last;
         rd_en_in      = head.corner_en[step_ff];
         rd_neg_in     = step_ff[0];
         rd_wr_addr_in = head.addr[1];
         rd_sum_in     = head.row_sum;
      end
      if (issue) begin
         hit_in = wr_en & (rd_addr == rd_wr_addr_ff);
         fwd_in = wr_data;
      end
   end

   // Accumulator restarts after the last corner of each query.
   always_comb begin
      acc_in = acc_ff;
      if (rd_valid_ff && !rd_load_ff && !stall) begin
         acc_in = rd_last_ff ? '0 : acc_step;
      end
   end

   // Output register.
   always_comb begin
      out_valid_in = result_en | (out_valid_ff & ~rsp_ready);
      out_sum_in   = result_en ? clamped : out_sum_ff;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_box_sum = out_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rd_valid_ff  <= rd_valid_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_load_ff    <= rd_load_in;
      rd_last_ff    <= rd_last_in;
      rd_en_ff      <= rd_en_in;
      rd_neg_ff     <= rd_neg_in;
      rd_wr_addr_ff <= rd_wr_addr_in;
      rd_sum_ff     <= rd_sum_in;
      hit_ff        <= hit_in;
      fwd_ff        <= fwd_in;
      out_sum_ff    <= out_sum_in;
   end

   // Table memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[rd_wr_addr_ff] <= wr_data;
      end
      if (issue) begin
         mem_q_ff <= table_ff[rd_addr];
      end
   end

`ifndef SYNTHESIS
   // A load never waits on the output register, so its write is never held.
   assert property (@(posedge clock) disable iff (reset) wr_en |-> !stall)
      else $error("table write during a stall");

   // A stall keeps the finished query and its partial sum in place.
   assert property (@(posedge clock) disable iff (reset)
      stall |=> rd_valid_ff && rd_last_ff && $stable(acc_ff))
      else $error("read stage changed during a stall");

   // A load always starts on the first step of the corner walk.
   assert property (@(posedge clock) disable iff (reset)
      issue && !head.is_query |-> step_ff == '0)
      else $error("load issued in the middle of a query");
`endif

endmodule

>>> test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import iibs_pkg::*;

   localparam int TABLE_ROWS     = DEFAULT_MAX_HEIGHT;
   localparam int TABLE_COLS     = DEFAULT_MAX_WIDTH;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int QUERY_PERCENT  = 35;

   typedef struct packed {
      logic               command;
      logic [PIXEL_W-1:0] pixel_red;
      logic               first_pixel;
      logic [COORD_W-1:0] top_row;
      logic [COORD_W-1:0] left_col;
      logic [COORD_W-1:0] row_count;
      logic [COORD_W-1:0] col_count;
   } box_req_t;

   typedef struct packed {
      box_req_t         req;
      logic             has_sum;
      logic [SUM_W-1:0] sum;
   } directed_row_t;

   typedef struct packed {
      logic [SIZE_REG_W-1:0] width;
      logic [SIZE_REG_W-1:0] height;
      logic [15:0]           items;
   } size_phase_t;

   logic                        clock;
   logic                        reset       = 1'b1;
   logic                        csr_valid   = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index   = '0;
   logic [SIZE_REG_W-1:0]       csr_wdata   = '0;
   logic                        req_valid   = 1'b0;
   logic                        req_ready;
   logic                        req_command = CMD_LOAD;
   logic [PIXEL_W-1:0]          req_pixel_red   = '0;
   logic                        req_first_pixel = 1'b0;
   logic signed [COORD_W-1:0]   req_top_row     = '0;
   logic signed [COORD_W-1:0]   req_left_col    = '0;
   logic [COORD_W-1:0]          req_row_count   = '0;
   logic [COORD_W-1:0]          req_col_count   = '0;
   logic                        rsp_valid;
   logic                        rsp_ready   = 1'b0;
   logic [SUM_W-1:0]            rsp_box_sum;

   // Shadow copy of the summed-area table and the raster position.
   logic [ENTRY_W-1:0]    sat_entries [TABLE_ROWS*TABLE_COLS];
   bit                    sat_written [TABLE_ROWS*TABLE_COLS];
   int                    raster_row = 0;
   int                    raster_col = 0;
   int                    row_sum    = 0;
   logic [SIZE_REG_W-1:0] width_reg  = SIZE_RESET;
   logic [SIZE_REG_W-1:0] height_reg = SIZE_RESET;

   logic [SUM_W-1:0] box_sums_due [$];
   int               mismatch_count = 0;
   int               stalled_cycles = 0;
   int               req_calm  = 0;
   int               rsp_calm  = 0;
   int               rsp_stall = 0;

   // Image is 4 wide and 2 tall while these run.
   directed_row_t directed_rows [24] = '{
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'd0,    11'd0,    11'd0,    11'd0},    1'b1, 26'd0},
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'h400,  11'h400,  11'd1024, 11'd2047}, 1'b1, 26'd0},
      '{'{CMD_LOAD,  8'd255, 1'b1, 11'd0,    11'd0,    11'd0,    11'd0},    1'b0, 26'd0},
      '{'{CMD_LOAD,  8'd0,   1'b0, 11'd0,    11'd0,    11'd0,    11'd0},    1'b0, 26'd0},
      '{'{CMD_LOAD,  8'd255, 1'b0, 11'd0,    11'd0,    11'd0,    11'd0},    1'b0, 26'd0},
      '{'{CMD_LOAD,  8'd128, 1'b0, 11'd0,    11'd0,    11'd0,    11'd0},    1'b0, 26'd0},
      '{'{CMD_LOAD,  8'd1,   1'b0, 11'd0,    11'd0,    11'd0,    11'd0},    1'b0, 26'd0},
      '{'{CMD_LOAD,  8'd255, 1'b0, 11'd0,    11'd0,    11'd0,    11'd0},    1'b0, 26'd0},
      '{'{CMD_LOAD,  8'd255, 1'b0, 11'd0,    11'd0,    11'd0,    11'd0},    1'b0, 26'd0},
      '{'{CMD_LOAD,  8'd255, 1'b0, 11'd0,    11'd0,    11'd0,    11'd0},    1'b0, 26'd0},
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'h400,  11'h400,  11'd2047, 11'd2047}, 1'b1, 26'd1404},
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'd1023, 11'd1023, 11'd2047, 11'd2047}, 1'b1, 26'd0},
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'd0,    11'd0,    11'd1,    11'd1},    1'b1, 26'd255},
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'd1,    11'd1,    11'd1,    11'd3},    1'b0, 26'd0},
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'h7FF,  11'h7FF,  11'd2,    11'd2},    1'b1, 26'd255},
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'd0,    11'd2,    11'd2,    11'd1},    1'b0, 26'd0},
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'd0,    11'd0,    11'd1024, 11'd1024}, 1'b1, 26'd1404},
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'd1,    11'd0,    11'd0,    11'd1024}, 1'b0, 26'd0},
      '{'{CMD_LOAD,  8'd7,   1'b0, 11'd0,    11'd0,    11'd0,    11'd0},    1'b0, 26'd0},
      '{'{CMD_LOAD,  8'd9,   1'b0, 11'd0,    11'd0,    11'd0,    11'd0},    1'b0, 26'd0},
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'd0,    11'd0,    11'd2,    11'd2},    1'b0, 26'd0},
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'd1,    11'd0,    11'd1,    11'd2},    1'b0, 26'd0},
      '{'{CMD_LOAD,  8'd200, 1'b1, 11'd0,    11'd0,    11'd0,    11'd0},    1'b0, 26'd0},
      '{'{CMD_QUERY, 8'd0,   1'b0, 11'd1,    11'd1,    11'd1,    11'd1},    1'b0, 26'd0}
   };

   // Image sizes for the random part, including zero and oversize register values.
   size_phase_t size_phases [10] = '{
      '{10'd0,    10'd0,    16'd30},
      '{10'd1023, 10'd1,    16'd60},
      '{10'd1,    10'd1023, 16'd60},
      '{10'd5,    10'd3,    16'd110},
      '{10'd7,    10'd7,    16'd130},
      '{10'd3,    10'd6,    16'd90},
      '{10'd16,   10'd9,    16'd120},
      '{10'd2,    10'd2,    16'd60},
      '{10'd512,  10'd2,    16'd80},
      '{10'd9,    10'd13,   16'd110}
   };

   integral_image_box_sum i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_pixel_red   (req_pixel_red),
      .req_first_pixel (req_first_pixel),
      .req_top_row     (req_top_row),
      .req_left_col    (req_left_col),
      .req_row_count   (req_row_count),
      .req_col_count   (req_col_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_box_sum     (rsp_box_sum)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A size register of zero means one; anything past the table means the table.
   function automatic int effective_dim(input logic [SIZE_REG_W-1:0] value, input int limit);
      if (value == '0) return 1;
      return (int'(value) > limit) ? limit : int'(value);
   endfunction

   // Entries outside the table or never written read as zero.
   function automatic longint entry_at(input int r, input int c);
      if (r < 0 || c < 0 || r >= TABLE_ROWS || c >= TABLE_COLS) return 0;
      if (!sat_written[r * TABLE_COLS + c]) return 0;
      return longint'(sat_entries[r * TABLE_COLS + c]);
   endfunction

   // True when reading this corner touches nothing but loaded entries.
   function automatic bit entry_ready(input int r, input int c);
      if (r < 0 || c < 0) return 1'b1;
      return sat_written[r * TABLE_COLS + c];
   endfunction

   // Table coordinates of the four corners after clamping the box to the image.
   function automatic void box_corners(input box_req_t t, output int r1, output int c1,
                                       output int r2, output int c2);
      int h;
      int w;
      int top;
      int left;
      int bottom;
      int right;
      h      = effective_dim(height_reg, TABLE_ROWS);
      w      = effective_dim(width_reg, TABLE_COLS);
      top    = int'($signed(t.top_row));
      left   = int'($signed(t.left_col));
      bottom = top + int'(t.row_count);
      right  = left + int'(t.col_count);
      r1 = ((top < h) ? top : h) - 1;
      c1 = ((left < w) ? left : w) - 1;
      r2 = ((bottom < h) ? bottom : h) - 1;
      c2 = ((right < w) ? right : w) - 1;
   endfunction

   function automatic logic [SUM_W-1:0] predict_box_sum(input box_req_t t);
      int     r1;
      int     c1;
      int     r2;
      int     c2;
      longint total;
      box_corners(t, r1, c1, r2, c2);
      total = entry_at(r1, c1) - entry_at(r1, c2) - entry_at(r2, c1) + entry_at(r2, c2);
      if (total < 0) total = 0;
      if (total > longint'(SUM_MAX)) total = longint'(SUM_MAX);
      return SUM_W'(total);
   endfunction

   // Store one pixel at the raster position and advance it.
   function automatic void store_pixel(input box_req_t t);
      int     w;
      int     h;
      int     idx;
      longint above;
      w = effective_dim(width_reg, TABLE_COLS);
      h = effective_dim(height_reg, TABLE_ROWS);
      if (t.first_pixel) begin
         raster_row = 0;
         raster_col = 0;
         row_sum    = 0;
      end
      row_sum = row_sum + int'(t.pixel_red);
      above   = (raster_row != 0) ? entry_at(raster_row - 1, raster_col) : 0;
      idx     = raster_row * TABLE_COLS + raster_col;
      sat_entries[idx] = ENTRY_W'(longint'(row_sum) + above);
      sat_written[idx] = 1'b1;
      raster_col++;
      if (raster_col >= w) begin
         raster_col = 0;
         row_sum    = 0;
         raster_row++;
         if (raster_row >= h) raster_row = 0;
      end
   endfunction

   // Mostly zero, sometimes a short gap, rarely a long pause.
   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Raster load with random content; the query fields carry noise.
   function automatic box_req_t random_load();
      box_req_t t;
      int       pick;
      pick          = $urandom_range(0, 99);
      t.command     = CMD_LOAD;
      t.pixel_red   = (pick < 10) ? '0 : (pick < 20) ? '1 : PIXEL_W'($urandom);
      t.first_pixel = ($urandom_range(0, 49) == 0);
      t.top_row     = COORD_W'($urandom);
      t.left_col    = COORD_W'($urandom);
      t.row_count   = COORD_W'($urandom);
      t.col_count   = COORD_W'($urandom);
      // Restart the raster when the entry above has not been loaded yet.
      if (!t.first_pixel && raster_row != 0 && !entry_ready(raster_row - 1, raster_col))
         t.first_pixel = 1'b1;
      return t;
   endfunction

   // Box query over loaded entries: mostly near the image, sometimes any field value.
   function automatic box_req_t random_query();
      box_req_t t;
      int       span_r;
      int       span_c;
      int       tries;
      int       r1;
      int       c1;
      int       r2;
      int       c2;
      span_r = effective_dim(height_reg, TABLE_ROWS);
      span_c = effective_dim(width_reg, TABLE_COLS);
      if (span_r > 40) span_r = 40;
      if (span_c > 40) span_c = 40;
      for (tries = 0; tries < 64; tries++) begin
         t.command     = CMD_QUERY;
         t.pixel_red   = PIXEL_W'($urandom);
         t.first_pixel = 1'($urandom);
         if ($urandom_range(0, 9) == 0) begin
            t.top_row   = COORD_W'($urandom);
            t.left_col  = COORD_W'($urandom);
            t.row_count = COORD_W'($urandom);
            t.col_count = COORD_W'($urandom);
         end else begin
            t.top_row   = COORD_W'(int'($urandom_range(0, span_r + 5)) - 3);
            t.left_col  = COORD_W'(int'($urandom_range(0, span_c + 5)) - 3);
            t.row_count = COORD_W'($urandom_range(0, span_r + 3));
            t.col_count = COORD_W'($urandom_range(0, span_c + 3));
         end
         box_corners(t, r1, c1, r2, c2);
         if (entry_ready(r1, c1) && entry_ready(r1, c2) &&
             entry_ready(r2, c1) && entry_ready(r2, c2))
            return t;
      end
      // Nothing loaded under the window yet: an empty box above and left of the image.
      t.top_row   = '1;
      t.left_col  = '1;
      t.row_count = '0;
      t.col_count = '0;
      return t;
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   // Present one request, wait for its transaction, then update the shadow state.
   task automatic send_request(input box_req_t t, input bit has_sum,
                               input logic [SUM_W-1:0] typed_sum);
      int gap;
      req_valid       <= 1'b1;
      req_command     <= t.command;
      req_pixel_red   <= t.pixel_red;
      req_first_pixel <= t.first_pixel;
      req_top_row     <= t.top_row;
      req_left_col    <= t.left_col;
      req_row_count   <= t.row_count;
      req_col_count   <= t.col_count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (t.command == CMD_QUERY)
         box_sums_due.push_back(has_sum ? typed_sum : predict_box_sum(t));
      else
         store_pixel(t);
      if (req_calm != 0) begin
         req_calm--;
         gap = 0;
      end else begin
         gap = idle_cycles();
         if ($urandom_range(0, 59) == 0) req_calm = $urandom_range(16, 48);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Write both size registers back to back, keeping valid high between them.
   task automatic configure_image(input logic [SIZE_REG_W-1:0] w,
                                  input logic [SIZE_REG_W-1:0] h);
      csr_valid <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      width_reg = w;
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      height_reg = h;
      csr_valid <= 1'b0;
   endtask

   // Drain outstanding sums, then give trailing loads time to finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (box_sums_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side stalls at random, with occasional stretches of steady ready.
   always @(posedge clock) begin
      if (rsp_calm != 0) begin
         rsp_calm--;
         rsp_ready <= 1'b1;
      end else if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) == 0) rsp_calm = $urandom_range(20, 80);
         else if ($urandom_range(0, 3) == 0) rsp_stall = idle_cycles();
      end
   end

   // Compare each returned sum with the oldest one outstanding.
   always @(posedge clock) begin : check_sums
      logic [SUM_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (box_sums_due.size() == 0) begin
            note_failure($sformatf("box sum %0d arrived with none outstanding", rsp_box_sum));
         end else begin
            want = box_sums_due.pop_front();
            if (rsp_box_sum !== want)
               note_failure($sformatf("box sum mismatch: expected %0d, got %0d",
                                      want, rsp_box_sum));
         end
      end
   end

   // End the run if no transaction completes for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("integral_image_box_sum verification failed");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin : run
      box_req_t t;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part on a 4 x 2 image.
      configure_image(10'd4, 10'd2);
      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].has_sum, directed_rows[i].sum);
      settle();

      // Random loads and queries under each image size.
      foreach (size_phases[p]) begin
         configure_image(size_phases[p].width, size_phases[p].height);
         for (int n = 0; n < int'(size_phases[p].items); n++) begin
            if ($urandom_range(0, 99) < QUERY_PERCENT) t = random_query();
            else t = random_load();
            send_request(t, 1'b0, '0);
         end
         settle();
      end

      if (box_sums_due.size() != 0)
         note_failure($sformatf("%0d box sums never arrived", box_sums_due.size()));
      if (mismatch_count == 0) begin
         $display("integral_image_box_sum verification clean");
      end else begin
         $display("integral_image_box_sum verification failed");
      end
      $finish;
   end

endmodule
